/* design/bal_pkg.sv */
`default_nettype none

package bal_pkg;

   // Field widths fixed by the interface
   localparam int OP_W  = 2;
   localparam int IDX_W = 8;
   localparam int CNT_W = 9;

   // Default geometry of the map
   localparam int NUM_BITS_DEFAULT  = 256;
   localparam int WORD_BITS_DEFAULT = 32;

   // Bit count after reset
   localparam int BITS_IN_USE_RESET = 256;

   typedef enum logic [OP_W-1:0] {
      OP_MARK  = 2'd0,
      OP_CLEAR = 2'd1,
      OP_TEST  = 2'd2,
      OP_FIND  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_EXEC  = 3'b100
   } state_type;

endpackage

`default_nettype wire

/* design/bitmap_allocator_unit.sv */
`default_nettype none

// Allocation bitmap with find-first-clear. Each transaction marks, clears or
// tests one bit, or finds the lowest clear bit below the configured bit count
// and marks it; every response carries the number of clear bits left. The map
// lives in a single memory of NUM_BITS/WORD_BITS words (rounded up), beside a
// flip-flop flag per word that tells which words still hold a clear bit. In
// the accept cycle the word is picked (from the flag vector for a find) and
// read; in the EXEC state it is modified, written back and the response
// register loaded. EXEC holds while a previous response is still stalled, and
// with its read-modify-write through the one memory port a new transaction is
// accepted only once the last one has left EXEC. After reset and after every
// write of the bit count the map is cleared by a pass that writes each of the
// NUM_WORDS words (8 at the default size), during which req_stall is high.
module bitmap_allocator_unit #(
   parameter int NUM_BITS  = bal_pkg::NUM_BITS_DEFAULT,
   parameter int WORD_BITS = bal_pkg::WORD_BITS_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,

   input  wire logic                        csr_write_enable,
   input  wire logic [bal_pkg::CNT_W-1:0]   csr_write_data,

   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [bal_pkg::OP_W-1:0]    req_operation,
   input  wire logic [bal_pkg::IDX_W-1:0]   req_bit_index,

   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [bal_pkg::IDX_W-1:0]        rsp_found_index,
   output logic                             rsp_found,
   output logic                             rsp_bit_value,
   output logic                             rsp_index_error,
   output logic [bal_pkg::CNT_W-1:0]        rsp_free_count
);
   import bal_pkg::*;

   localparam int NUM_WORDS = (NUM_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int BOFF_W    = $clog2(WORD_BITS);
   localparam int SPAN_W    = $clog2(NUM_WORDS * WORD_BITS + 1);
   localparam int POS_W     = (SPAN_W > CNT_W) ? SPAN_W : CNT_W;
   localparam int EFF_RESET = (NUM_BITS < BITS_IN_USE_RESET) ? NUM_BITS : BITS_IN_USE_RESET;

   // Word holding a bit index
   function automatic logic [WADDR_W-1:0] idx_word(input logic [IDX_W-1:0] idx);
      logic [WADDR_W-1:0] w_sel;
      w_sel = '0;
      for (int w = 1; w < NUM_WORDS; w++) begin
         if (int'(idx) >= w * WORD_BITS) begin
            w_sel = WADDR_W'(w);
         end
      end
      return w_sel;
   endfunction

   // Lowest flagged word
   function automatic logic [WADDR_W-1:0] first_word(input logic [NUM_WORDS-1:0] vec);
      logic [WADDR_W-1:0] w_sel;
      w_sel = '0;
      for (int w = NUM_WORDS - 1; w >= 0; w--) begin
         if (vec[w]) begin
            w_sel = WADDR_W'(w);
         end
      end
      return w_sel;
   endfunction

   // Lowest set bit within a word
   function automatic logic [BOFF_W-1:0] first_bit(input logic [WORD_BITS-1:0] vec);
      logic [BOFF_W-1:0] b_sel;
      b_sel = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (vec[b]) begin
            b_sel = BOFF_W'(b);
         end
      end
      return b_sel;
   endfunction

   state_type              state_ff, state_in;
   logic [WADDR_W-1:0]     clr_addr_ff, clr_addr_in;
   logic [CNT_W-1:0]       eff_count_ff, eff_count_in;
   logic [CNT_W-1:0]       clear_count_ff, clear_count_in;
   logic [NUM_WORDS-1:0]   has_clear_ff, has_clear_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   op_type                 op_ff, op_in;
   logic [WADDR_W-1:0]     word_ff, word_in;
   logic [BOFF_W-1:0]      off_ff, off_in;
   logic                   err_ff, err_in;
   logic                   hit_ff, hit_in;

   logic [IDX_W-1:0]       found_index_ff, found_index_in;
   logic                   found_ff, found_in;
   logic                   bit_value_ff, bit_value_in;
   logic                   index_error_ff, index_error_in;
   logic [CNT_W-1:0]       free_count_ff, free_count_in;

   logic [WORD_BITS-1:0]   map_mem [NUM_WORDS];
   logic [WORD_BITS-1:0]   rd_data_ff;
   logic                   mem_re;
   logic                   mem_we;
   logic [WADDR_W-1:0]     mem_raddr;
   logic [WADDR_W-1:0]     mem_waddr;
   logic [WORD_BITS-1:0]   mem_wdata;

   logic                   accept;
   logic                   rsp_take;
   logic                   exec_done;
   op_type                 req_op;
   logic [WADDR_W-1:0]     req_word;

   logic [POS_W-1:0]       base;
   logic [POS_W-1:0]       lim;
   logic [WORD_BITS-1:0]   avail;
   logic                   find_hit;
   logic [BOFF_W-1:0]      find_off;
   logic [BOFF_W-1:0]      sel_off;
   logic                   cur_bit;
   logic                   set_bit;
   logic                   clr_bit;
   logic [WORD_BITS-1:0]   new_word;

   assign req_op    = op_type'(req_operation);
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign exec_done = (state_ff == ST_EXEC) && !(rsp_valid_ff && rsp_stall);
   assign req_word  = (req_op == OP_FIND) ? first_word(has_clear_ff) : idx_word(req_bit_index);

   // Modify stage: locate the target bit in the word just read
   always_comb begin
      base = POS_W'(int'(word_ff) * WORD_BITS);
      lim  = (POS_W'(eff_count_ff) > base) ? (POS_W'(eff_count_ff) - base) : '0;
      for (int b = 0; b < WORD_BITS; b++) begin
         avail[b] = !rd_data_ff[b] && (POS_W'(b) < lim);
      end
      find_hit = (op_ff == OP_FIND) && hit_ff && (|avail);
      find_off = first_bit(avail);
      sel_off  = (op_ff == OP_FIND) ? find_off : off_ff;
      cur_bit  = rd_data_ff[off_ff];
      set_bit  = ((op_ff == OP_FIND) && find_hit) ||
                 ((op_ff == OP_MARK) && !err_ff && !cur_bit);
      clr_bit  = (op_ff == OP_CLEAR) && !err_ff && cur_bit;
      new_word = rd_data_ff;
      new_word[sel_off] = set_bit;
   end

   always_comb begin
      mem_re    = accept;
      mem_raddr = req_word;
      mem_we    = 1'b0;
      mem_waddr = word_ff;
      mem_wdata = new_word;
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
      end else if (exec_done && (set_bit || clr_bit)) begin
         mem_we = 1'b1;
      end
   end

   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      eff_count_in   = eff_count_ff;
      clear_count_in = clear_count_ff;
      has_clear_in   = has_clear_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_take;

      op_in          = op_ff;
      word_in        = word_ff;
      off_in         = off_ff;
      err_in         = err_ff;
      hit_in         = hit_ff;

      found_index_in = found_index_ff;
      found_in       = found_ff;
      bit_value_in   = bit_value_ff;
      index_error_in = index_error_ff;
      free_count_in  = free_count_ff;

      case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == WADDR_W'(NUM_WORDS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_op;
               word_in  = req_word;
               off_in   = BOFF_W'(int'(req_bit_index) - int'(req_word) * WORD_BITS);
               err_in   = (req_op != OP_FIND) &&
                          ({1'b0, req_bit_index} >= eff_count_ff);
               hit_in   = |has_clear_ff;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_done) begin
               if (set_bit) begin
                  clear_count_in = clear_count_ff - 1'b1;
               end else if (clr_bit) begin
                  clear_count_in = clear_count_ff + 1'b1;
               end
               if (set_bit || clr_bit) begin
                  has_clear_in[word_ff] = ~(&new_word);
               end
               found_index_in = find_hit ? IDX_W'(base + POS_W'(find_off)) : '0;
               found_in       = find_hit;
               bit_value_in   = (op_ff == OP_TEST) && !err_ff && cur_bit;
               index_error_in = err_ff;
               free_count_in  = clear_count_in;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A new bit count rebuilds the map
      if (csr_write_enable) begin
         eff_count_in   = (int'(csr_write_data) > NUM_BITS) ? CNT_W'(NUM_BITS) : csr_write_data;
         clear_count_in = eff_count_in;
         has_clear_in   = '1;
         clr_addr_in    = '0;
         state_in       = ST_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_addr_ff    <= '0;
         eff_count_ff   <= CNT_W'(EFF_RESET);
         clear_count_ff <= CNT_W'(EFF_RESET);
         has_clear_ff   <= '1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_addr_ff    <= clr_addr_in;
         eff_count_ff   <= eff_count_in;
         clear_count_ff <= clear_count_in;
         has_clear_ff   <= has_clear_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      word_ff        <= word_in;
      off_ff         <= off_in;
      err_ff         <= err_in;
      hit_ff         <= hit_in;
      found_index_ff <= found_index_in;
      found_ff       <= found_in;
      bit_value_ff   <= bit_value_in;
      index_error_ff <= index_error_in;
      free_count_ff  <= free_count_in;
   end

   // Map memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= map_mem[mem_raddr];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found_index = found_index_ff;
   assign rsp_found       = found_ff;
   assign rsp_bit_value   = bit_value_ff;
   assign rsp_index_error = index_error_ff;
   assign rsp_free_count  = free_count_ff;

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      (accept && !csr_write_enable) |=> (state_ff == ST_EXEC))
      else $error("accepted transaction did not enter the modify stage");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      clear_count_ff <= eff_count_ff)
      else $error("clear count exceeds managed bit count");

   a_found_no_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_found) |-> !rsp_index_error)
      else $error("find response flags an index error");

   a_csr_clears: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> (state_ff == ST_CLEAR) && (&has_clear_ff))
      else $error("bit count write did not start the clearing pass");

endmodule

`default_nettype wire
